// File: src/hkvs_pkg.sv
// ----------------------------------------------------------------------------
// hkvs_pkg
// Shared types and constants of the hashed key-value store: operation and
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package hkvs_pkg;

    localparam logic [31:0] GOLD_FRAC = 32'hB7E1_5162;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_BUCKET,
        S_READ,
        S_EXEC,
        S_CLEAR
    } t_state;

    typedef struct packed {
        logic load;
        logic hash;
        logic bucket;
        logic read;
        logic exec;
        logic sweep;
        logic clear_done;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic sweep_last;
    } t_dp_stat;

endpackage

// File: src/hkvs_ctrl.sv
// ----------------------------------------------------------------------------
// hkvs_ctrl
// Controller of the key-value store. Steps each request through hashing,
// bucket read and execution, and runs the fill-count clearing sweep.
// ----------------------------------------------------------------------------
module hkvs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  hkvs_pkg::t_dp_stat i_stat,
    output hkvs_pkg::t_cmd     o_cmd,
    output logic               busy
);

    hkvs_pkg::t_state r_state;
    hkvs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hkvs_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            hkvs_pkg::S_INIT: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = hkvs_pkg::S_IDLE;
                end
            end
            hkvs_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = hkvs_pkg::S_HASH;
                end
            end
            hkvs_pkg::S_HASH: begin
                o_cmd.hash = 1'b1;
                n_state    = i_stat.is_clear ? hkvs_pkg::S_CLEAR : hkvs_pkg::S_BUCKET;
            end
            hkvs_pkg::S_BUCKET: begin
                o_cmd.bucket = 1'b1;
                n_state      = hkvs_pkg::S_READ;
            end
            hkvs_pkg::S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = hkvs_pkg::S_EXEC;
            end
            hkvs_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = hkvs_pkg::S_IDLE;
            end
            hkvs_pkg::S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.clear_done = 1'b1;
                    n_state          = hkvs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hkvs_pkg::S_INIT;
            end
        endcase
    end

    assign busy = (r_state != hkvs_pkg::S_IDLE);

endmodule

// File: src/hkvs_dpath.sv
// ----------------------------------------------------------------------------
// hkvs_dpath
// Datapath of the key-value store: request registers, the two-step
// multiplicative hash, the bucket row and fill-count memories, the parallel
// way compare with insert and delete row updates, and the result register.
// ----------------------------------------------------------------------------
module hkvs_dpath #(
    parameter int BUCKETS = 128,
    parameter int WAYS    = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hkvs_pkg::t_cmd     i_cmd,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_lookup_key,
    input  logic [63:0]        i_value_in,
    output hkvs_pkg::t_dp_stat o_stat,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic [63:0]        o_value_out
);

    localparam int BW = $clog2(BUCKETS);
    localparam int FW = $clog2(WAYS + 1);
    localparam int PW = 33 + BW;

    logic [WAYS-1:0][31:0] r_key_mem [BUCKETS];
    logic [WAYS-1:0][63:0] r_val_mem [BUCKETS];
    logic [FW-1:0]         r_fill_mem [BUCKETS];

    hkvs_pkg::t_mode       r_mode;
    logic [31:0]           r_key;
    logic [63:0]           r_val;
    logic [31:0]           r_frac;
    logic [BW-1:0]         r_bucket;
    logic [BW-1:0]         r_sweep;
    logic [BW-1:0]         n_sweep;
    logic [WAYS-1:0][31:0] r_keys_q;
    logic [WAYS-1:0][63:0] r_vals_q;
    logic [FW-1:0]         r_fill_q;
    logic                  r_strobe;
    hkvs_pkg::t_status     r_status;
    logic [63:0]           r_value;

    logic [PW-1:0]         bucket_prod;
    logic [WAYS-1:0]       hit;
    logic                  found;
    logic [FW-1:0]         hit_idx;
    logic [63:0]           hit_val;
    logic [WAYS-1:0][31:0] n_keys;
    logic [WAYS-1:0][63:0] n_vals;
    logic [FW-1:0]         n_fill;
    logic                  row_we;
    logic                  fill_we;
    logic [BW-1:0]         fill_addr;
    logic [FW-1:0]         fill_wdata;
    hkvs_pkg::t_status     n_status;
    logic [63:0]           n_value;

    assign bucket_prod = PW'(r_frac) * PW'(BUCKETS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= hkvs_pkg::t_mode'(i_mode);
            r_key  <= i_lookup_key;
            r_val  <= i_value_in;
        end
        if (i_cmd.hash) begin
            r_frac <= r_key * hkvs_pkg::GOLD_FRAC;
        end
        if (i_cmd.bucket) begin
            r_bucket <= bucket_prod[32 +: BW];
        end
    end

    assign o_stat.is_clear   = (r_mode == hkvs_pkg::MODE_CLEAR);
    assign o_stat.sweep_last = (r_sweep == BW'(BUCKETS - 1));

    always_comb begin
        n_sweep = r_sweep;
        if (i_cmd.sweep) begin
            n_sweep = o_stat.sweep_last ? '0 : r_sweep + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else begin
            r_sweep <= n_sweep;
        end
    end

    always_comb begin
        found   = 1'b0;
        hit_idx = '0;
        hit_val = '0;
        for (int i = 0; i < WAYS; i++) begin
            hit[i] = (FW'(i) < r_fill_q) && (r_keys_q[i] == r_key);
            if (hit[i]) begin
                found   = 1'b1;
                hit_idx = FW'(i);
                hit_val = r_vals_q[i];
            end
        end
    end

    always_comb begin
        n_keys   = r_keys_q;
        n_vals   = r_vals_q;
        n_fill   = r_fill_q;
        row_we   = 1'b0;
        n_status = hkvs_pkg::ST_OK;
        n_value  = '0;
        unique case (r_mode)
            hkvs_pkg::MODE_INSERT: begin
                if (r_fill_q >= FW'(WAYS)) begin
                    n_status = hkvs_pkg::ST_FULL;
                end else begin
                    for (int i = 0; i < WAYS; i++) begin
                        if (FW'(i) == r_fill_q) begin
                            n_keys[i] = r_key;
                            n_vals[i] = r_val;
                        end
                    end
                    n_fill = r_fill_q + 1'b1;
                    row_we = 1'b1;
                end
            end
            hkvs_pkg::MODE_SEARCH: begin
                if (found) begin
                    n_value = hit_val;
                end else begin
                    n_status = hkvs_pkg::ST_MISS;
                end
            end
            hkvs_pkg::MODE_DELETE: begin
                if (found) begin
                    for (int i = 1; i < WAYS; i++) begin
                        if (FW'(i) > hit_idx) begin
                            n_keys[i-1] = r_keys_q[i];
                            n_vals[i-1] = r_vals_q[i];
                        end
                    end
                    n_fill = r_fill_q - 1'b1;
                    row_we = 1'b1;
                end else begin
                    n_status = hkvs_pkg::ST_MISS;
                end
            end
            hkvs_pkg::MODE_CLEAR: begin
                n_status = hkvs_pkg::ST_OK;
            end
            default: begin
                n_status = hkvs_pkg::ST_OK;
            end
        endcase
    end

    assign fill_we    = i_cmd.sweep || (i_cmd.exec && row_we);
    assign fill_addr  = i_cmd.sweep ? r_sweep : r_bucket;
    assign fill_wdata = i_cmd.sweep ? '0 : n_fill;

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            r_fill_mem[fill_addr] <= fill_wdata;
        end
        if (i_cmd.read) begin
            r_fill_q <= r_fill_mem[r_bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && row_we) begin
            r_key_mem[r_bucket] <= n_keys;
            r_val_mem[r_bucket] <= n_vals;
        end
        if (i_cmd.read) begin
            r_keys_q <= r_key_mem[r_bucket];
            r_vals_q <= r_val_mem[r_bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.exec || i_cmd.clear_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_value  <= n_value;
        end else if (i_cmd.clear_done) begin
            r_status <= hkvs_pkg::ST_OK;
            r_value  <= '0;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_value_out = r_value;

endmodule

// File: src/hashed_key_value_store_unit.sv
// ----------------------------------------------------------------------------
// hashed_key_value_store_unit
// Bucketed hash table with BUCKETS buckets of WAYS slots, hashed by the
// fractional part of the key times (e - 2) in 0.32 fixed point.
//
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      i_mode, i_lookup_key, i_value_in
// result    out        o_strobe, one cycle       o_status, o_value_out
//
// Insert, search and delete step from one accepted request to the next
// through hash multiply, bucket scaling multiply, row read, compare and
// write, and the idle state that accepts the next request.
// Clear steps through the hash state, the sweep over the fill-count
// memory and the idle state.
// After reset the same sweep runs over the fill-count memory with busy held high.
// The result strobe follows the last cycle of the request; results cannot stall.
// ----------------------------------------------------------------------------
module hashed_key_value_store_unit #(
    parameter int BUCKETS = 128,
    parameter int WAYS    = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_lookup_key,
    input  logic [63:0]        i_value_in,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic [63:0]        o_value_out
);

    hkvs_pkg::t_cmd     cmd;
    hkvs_pkg::t_dp_stat stat;

    hkvs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    hkvs_dpath #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_mode       (i_mode),
        .i_lookup_key (i_lookup_key),
        .i_value_in   (i_value_in),
        .o_stat       (stat),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_value_out  (o_value_out)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted request did not raise busy.");

    a_exec_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> o_strobe)
        else $error("Executed request gave no result strobe.");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("Result strobe held for more than one cycle.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != hkvs_pkg::ST_OK) |-> (o_value_out == 64'd0))
        else $error("Failed request returned a nonzero value.");

endmodule

// File: sim/hashed_key_value_store_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_key_value_store_unit_tb
// Self-checking bench for the hashed key-value store. A table model kept
// inside a small scoreboard predicts the status and payload of every
// accepted request. Directed requests cover empty and full buckets, deletes
// that shift newer entries, shadowed duplicates, clear and the extreme keys
// and payloads. Random traffic follows, concentrated on a few crowded
// buckets, under several sender idle patterns.
// ----------------------------------------------------------------------------
module hashed_key_value_store_unit_tb;

    localparam int BUCKETS     = 128;
    localparam int WAYS        = 4;
    localparam int HOT_BUCKETS = 4;
    localparam int HOT_KEYS    = WAYS + 1;
    localparam int RANDOM_REQS = 800;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        hkvs_pkg::t_status status;
        logic [63:0]       value;
    } t_reply;

    function automatic int bucket_index(logic [31:0] key);
        logic [31:0] frac;
        logic [63:0] scaled;
        frac = key * hkvs_pkg::GOLD_FRAC;
        scaled = {32'd0, frac} * 64'(BUCKETS);
        return int'(scaled[63:32] % BUCKETS);
    endfunction

    class kv_reply_scoreboard;
        logic [2:0]  fill [BUCKETS];
        logic [31:0] keys [BUCKETS*WAYS];
        logic [63:0] vals [BUCKETS*WAYS];
        t_reply      pending_replies[$];
        int          errors;
        int          mode_count [4];
        int          hits;
        int          misses;
        int          full_inserts;

        function new();
            errors = 0;
            hits = 0;
            misses = 0;
            full_inserts = 0;
            foreach (mode_count[m]) mode_count[m] = 0;
            foreach (fill[b]) fill[b] = '0;
        endfunction

        function int newest_match(int base, int count, logic [31:0] key);
            for (int i = count - 1; i >= 0; i--) begin
                if (keys[base + i] == key) return i;
            end
            return -1;
        endfunction

        function void book_request(hkvs_pkg::t_mode mode, logic [31:0] key,
                                   logic [63:0] val);
            t_reply r;
            int     b;
            int     base;
            int     idx;
            b = bucket_index(key);
            base = b * WAYS;
            r.status = hkvs_pkg::ST_OK;
            r.value = '0;
            mode_count[mode]++;
            case (mode)
                hkvs_pkg::MODE_INSERT: begin
                    if (fill[b] >= WAYS) begin
                        r.status = hkvs_pkg::ST_FULL;
                        full_inserts++;
                    end else begin
                        keys[base + fill[b]] = key;
                        vals[base + fill[b]] = val;
                        fill[b] = fill[b] + 3'd1;
                    end
                end
                hkvs_pkg::MODE_SEARCH: begin
                    idx = newest_match(base, fill[b], key);
                    if (idx < 0) begin
                        r.status = hkvs_pkg::ST_MISS;
                        misses++;
                    end else begin
                        r.value = vals[base + idx];
                        hits++;
                    end
                end
                hkvs_pkg::MODE_DELETE: begin
                    idx = newest_match(base, fill[b], key);
                    if (idx < 0) begin
                        r.status = hkvs_pkg::ST_MISS;
                        misses++;
                    end else begin
                        for (int i = idx; i + 1 < fill[b]; i++) begin
                            keys[base + i] = keys[base + i + 1];
                            vals[base + i] = vals[base + i + 1];
                        end
                        fill[b] = fill[b] - 3'd1;
                        hits++;
                    end
                end
                default: begin
                    foreach (fill[i]) fill[i] = '0;
                end
            endcase
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [1:0] status, logic [63:0] value);
            t_reply r;
            if (pending_replies.size() == 0) begin
                $display("%0t: result with no request pending: status %0d value %h",
                         $time, status, value);
                errors++;
                return;
            end
            r = pending_replies.pop_front();
            if (status !== r.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, r.status, status);
                errors++;
            end
            if (value !== r.value) begin
                $display("%0t: value_out mismatch: expected %h actual %h",
                         $time, r.value, value);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n      = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic [1:0]         i_mode       = hkvs_pkg::MODE_INSERT;
    logic signed [31:0] i_lookup_key = '0;
    logic [63:0]        i_value_in   = '0;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic [63:0]        o_value_out;

    kv_reply_scoreboard sb;
    int                 idle_pct = 0;
    int                 cycles   = 0;
    logic [31:0]        hot_keys [HOT_BUCKETS][HOT_KEYS];
    logic [31:0]        edge_keys [4];

    hashed_key_value_store_unit #(
        .BUCKETS(BUCKETS),
        .WAYS   (WAYS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_lookup_key(i_lookup_key),
        .i_value_in  (i_value_in),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_value_out (o_value_out)
    );

    function automatic logic [31:0] key_in_bucket(int b);
        logic [31:0] k;
        do k = $urandom(); while (bucket_index(k) != b);
        return k;
    endfunction

    function automatic logic [63:0] random_value();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("hashed_key_value_store_unit_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_reply(o_status, o_value_out);
    end

    task automatic send_request(input hkvs_pkg::t_mode mode, input logic [31:0] key,
                                input logic [63:0] val);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 8);
        repeat (gap) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_mode       <= mode;
        i_lookup_key <= key;
        i_value_in   <= val;
        do @(posedge i_clk); while (!(start && !busy));
        sb.book_request(mode, key, val);
    endtask

    task automatic run_directed();
        logic [31:0] k [HOT_KEYS];
        k = hot_keys[0];
        send_request(hkvs_pkg::MODE_SEARCH, k[0], random_value());
        send_request(hkvs_pkg::MODE_DELETE, k[0], random_value());
        send_request(hkvs_pkg::MODE_INSERT, k[0], 64'h0);
        send_request(hkvs_pkg::MODE_INSERT, k[1], 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(hkvs_pkg::MODE_INSERT, k[2], 64'h8000_0000_0000_0000);
        send_request(hkvs_pkg::MODE_INSERT, k[3], random_value());
        send_request(hkvs_pkg::MODE_INSERT, k[4], random_value());
        send_request(hkvs_pkg::MODE_SEARCH, k[2], random_value());
        send_request(hkvs_pkg::MODE_DELETE, k[1], random_value());
        send_request(hkvs_pkg::MODE_SEARCH, k[3], random_value());
        send_request(hkvs_pkg::MODE_SEARCH, k[1], random_value());
        send_request(hkvs_pkg::MODE_INSERT, k[3], random_value());
        send_request(hkvs_pkg::MODE_SEARCH, k[3], random_value());
        send_request(hkvs_pkg::MODE_DELETE, k[3], random_value());
        send_request(hkvs_pkg::MODE_SEARCH, k[3], random_value());
        send_request(hkvs_pkg::MODE_DELETE, k[4], random_value());
        send_request(hkvs_pkg::MODE_CLEAR, k[0], random_value());
        send_request(hkvs_pkg::MODE_SEARCH, k[0], random_value());
        foreach (edge_keys[i]) begin
            send_request(hkvs_pkg::MODE_INSERT, edge_keys[i], ~64'(i));
        end
        foreach (edge_keys[i]) begin
            send_request(hkvs_pkg::MODE_SEARCH, edge_keys[i], random_value());
        end
    endtask

    task automatic run_random(input int count);
        hkvs_pkg::t_mode mode;
        logic [31:0]     key;
        int              r;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 42)      mode = hkvs_pkg::MODE_INSERT;
            else if (r < 72) mode = hkvs_pkg::MODE_SEARCH;
            else if (r < 97) mode = hkvs_pkg::MODE_DELETE;
            else             mode = hkvs_pkg::MODE_CLEAR;
            r = $urandom_range(99);
            if (r < 70)
                key = hot_keys[$urandom_range(HOT_BUCKETS - 1)][$urandom_range(HOT_KEYS - 1)];
            else if (r < 78)
                key = edge_keys[$urandom_range(3)];
            else
                key = $urandom();
            send_request(mode, key, random_value());
        end
    endtask

    initial begin
        int phase_idle [3];
        sb = new();
        phase_idle = '{0, 55, 35};
        edge_keys = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        for (int h = 0; h < HOT_BUCKETS; h++) begin
            int b;
            b = $urandom_range(BUCKETS - 1);
            for (int j = 0; j < HOT_KEYS; j++) hot_keys[h][j] = key_in_bucket(b);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        foreach (phase_idle[p]) begin
            idle_pct = phase_idle[p];
            run_random(RANDOM_REQS / 3);
        end
        start <= 1'b0;

        while (sb.pending_replies.size() > 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Requests: %0d insert, %0d search, %0d delete, %0d clear.",
                 sb.mode_count[hkvs_pkg::MODE_INSERT],
                 sb.mode_count[hkvs_pkg::MODE_SEARCH],
                 sb.mode_count[hkvs_pkg::MODE_DELETE],
                 sb.mode_count[hkvs_pkg::MODE_CLEAR]);
        $display("Lookups hit %0d times and missed %0d times; %0d inserts found a full bucket.",
                 sb.hits, sb.misses, sb.full_inserts);
        if (sb.errors == 0) begin
            $display("hashed_key_value_store_unit_tb passed");
        end else begin
            $display("hashed_key_value_store_unit_tb failed");
        end
        $finish;
    end

endmodule
